// File: sv/cpnm_pkg.sv
package cpnm_pkg;

  localparam int PAL_DEPTH  = 256;
  localparam int BASE_DEPTH = 16;
  localparam int CUBE_FIRST = 16;
  localparam int CUBE_LAST  = 231;
  localparam int CUBE_SIDE  = 6;
  localparam int CUBE_PLANE = 36;
  localparam int CUBE_STEP  = 40;
  localparam int CUBE_BASE  = 55;
  localparam int GREY_FIRST = 232;
  localparam int GREY_STEP  = 10;
  localparam int GREY_BASE  = 8;

  localparam logic [2:0] OP_SET         = 3'd0;
  localparam logic [2:0] OP_GET         = 3'd1;
  localparam logic [2:0] OP_RESET_ENTRY = 3'd2;
  localparam logic [2:0] OP_RESET_ALL   = 3'd3;
  localparam logic [2:0] OP_MATCH       = 3'd4;
  localparam logic [2:0] OP_LOAD        = 3'd5;

  typedef logic [23:0] colour_t;
  typedef colour_t fixed_tbl_t [PAL_DEPTH];

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] palette_index;
    colour_t    colour_value;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cpnm_in_t;

  typedef struct packed {
    colour_t    colour_out;
    logic [7:0] match_index;
  } cpnm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_SWEEP,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic cnt_clr;
    logic scan_issue;
    logic sweep_wr;
    logic load_out;
  } cpnm_cmd_t;

  typedef struct packed {
    logic cnt_base_end;
    logic cnt_end;
  } cpnm_status_t;

  function automatic logic [7:0] swap_half(input logic [7:0] idx);
    logic [7:0] res;
    res = idx;
    if (idx[7:4] == 4'd0 && idx[2:0] != 3'd0) begin
      res = idx ^ 8'd8;
    end
    return res;
  endfunction

  function automatic logic [7:0] cube_level(input int lvl);
    int v;
    v = (lvl == 0) ? 0 : lvl * CUBE_STEP + CUBE_BASE;
    return v[7:0];
  endfunction

  function automatic fixed_tbl_t build_fixed_tbl();
    fixed_tbl_t t;
    int         n;
    int         g;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      t[i] = '0;
    end
    for (int r = 0; r < CUBE_SIDE; r++) begin
      for (int gr = 0; gr < CUBE_SIDE; gr++) begin
        for (int b = 0; b < CUBE_SIDE; b++) begin
          n = CUBE_FIRST + r * CUBE_PLANE + gr * CUBE_SIDE + b;
          t[n] = {cube_level(b), cube_level(gr), cube_level(r)};
        end
      end
    end
    for (int i = GREY_FIRST; i < PAL_DEPTH; i++) begin
      g = (i - GREY_FIRST) * GREY_STEP + GREY_BASE;
      t[i] = {g[7:0], g[7:0], g[7:0]};
    end
    return t;
  endfunction

  localparam fixed_tbl_t FIXED_TBL = build_fixed_tbl();

endpackage

// File: sv/cpnm_ctrl.sv
module cpnm_ctrl
  import cpnm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [2:0]   in_op,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  cpnm_status_t status,
  output cpnm_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;
  logic        out_free;

  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_r)
          OP_MATCH:     state_nxt = ST_SCAN;
          OP_RESET_ALL: state_nxt = ST_SWEEP;
          default:      state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (status.cnt_end) begin
          state_nxt = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_DONE;
      ST_SWEEP: begin
        if (status.cnt_base_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = (state_r != ST_IDLE);
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          op_nxt      = in_op;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      ST_SCAN:  cmd.scan_issue = 1'b1;
      ST_SWEEP: cmd.sweep_wr   = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/cpnm_dpath.sv
module cpnm_dpath
  import cpnm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  cpnm_in_t     in_data,
  output cpnm_out_t    out_data,
  input  cpnm_cmd_t    cmd,
  output cpnm_status_t status
);

  cpnm_in_t            item_r;
  logic                mode_r;
  colour_t             dflt_r [BASE_DEPTH];
  logic [PAL_DEPTH-1:0] valid_r, valid_nxt;
  colour_t             mem [PAL_DEPTH];
  colour_t             rd_data_r;
  logic                rd_valid_r;
  colour_t             rd_fixed_r;
  colour_t             rd_colour;
  logic [7:0]          cnt_r;
  logic                p1_vld_r, p2_vld_r;
  logic [7:0]          p1_idx_r, p2_idx_r;
  logic [15:0]         sq_r [3];
  logic [15:0]         sq_nxt [3];
  logic [17:0]         best_dist_r;
  logic [7:0]          best_idx_r;
  logic [17:0]         dist_sum;
  cpnm_out_t           out_r;

  logic                we;
  logic [7:0]          waddr;
  colour_t             wdata;
  logic                re;
  logic [7:0]          raddr;
  logic [7:0]          a_addr;
  logic [7:0]          base_src;
  logic [7:0]          sweep_src;
  logic [7:0]          comp [3];
  logic [7:0]          want [3];
  logic [7:0]          diff [3];

  assign a_addr    = mode_r ? item_r.palette_index : swap_half(item_r.palette_index);
  assign base_src  = swap_half(a_addr);
  assign sweep_src = swap_half({4'd0, cnt_r[3:0]});

  assign status.cnt_base_end = (cnt_r == 8'(BASE_DEPTH - 1));
  assign status.cnt_end      = (cnt_r == 8'(PAL_DEPTH - 1));

  always_comb begin
    we        = 1'b0;
    waddr     = a_addr;
    wdata     = item_r.colour_value;
    re        = 1'b0;
    raddr     = a_addr;
    valid_nxt = valid_r;
    if (cmd.exec) begin
      case (item_r.operation)
        OP_SET: begin
          we               = 1'b1;
          valid_nxt[a_addr] = 1'b1;
        end
        OP_GET: re = 1'b1;
        OP_RESET_ENTRY: begin
          if (a_addr[7:4] == 4'd0) begin
            we                = 1'b1;
            wdata             = dflt_r[base_src[3:0]];
            valid_nxt[a_addr] = 1'b1;
          end else begin
            valid_nxt[a_addr] = 1'b0;
          end
        end
        OP_RESET_ALL: valid_nxt = '0;
        default: ;
      endcase
    end
    if (cmd.sweep_wr) begin
      we               = 1'b1;
      waddr            = cnt_r;
      wdata            = dflt_r[sweep_src[3:0]];
      valid_nxt[cnt_r] = 1'b1;
    end
    if (cmd.scan_issue) begin
      re    = 1'b1;
      raddr = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r  <= mem[raddr];
      rd_valid_r <= valid_r[raddr];
      rd_fixed_r <= FIXED_TBL[raddr];
    end
  end

  assign rd_colour = rd_valid_r ? rd_data_r : rd_fixed_r;

  assign comp[0] = rd_colour[7:0];
  assign comp[1] = rd_colour[15:8];
  assign comp[2] = rd_colour[23:16];
  assign want[0] = item_r.red;
  assign want[1] = item_r.green;
  assign want[2] = item_r.blue;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]   = (comp[k] > want[k]) ? comp[k] - want[k] : want[k] - comp[k];
      sq_nxt[k] = diff[k] * diff[k];
    end
  end

  assign dist_sum = 18'(sq_r[0]) + 18'(sq_r[1]) + 18'(sq_r[2]);

  always_ff @(posedge clk) begin
    p1_idx_r <= cnt_r;
    p2_idx_r <= p1_idx_r;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= sq_nxt[k];
    end
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r.colour_out  <= (item_r.operation == OP_GET) ? rd_colour : '0;
      out_r.match_index <= (item_r.operation != OP_MATCH) ? 8'd0 :
                           (mode_r ? swap_half(best_idx_r) : best_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      best_dist_r <= '0;
      best_idx_r  <= '0;
      for (int k = 0; k < BASE_DEPTH; k++) begin
        dflt_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      valid_r  <= valid_nxt;
      p1_vld_r <= cmd.scan_issue;
      p2_vld_r <= p1_vld_r;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.scan_issue || cmd.sweep_wr) begin
        cnt_r <= cnt_r + 8'd1;
      end
      if (cmd.exec && item_r.operation == OP_LOAD && item_r.palette_index[7:4] == 4'd0) begin
        dflt_r[item_r.palette_index[3:0]] <= item_r.colour_value;
      end
      if (p2_vld_r && (p2_idx_r == 8'd0 || dist_sum < best_dist_r)) begin
        best_dist_r <= dist_sum;
        best_idx_r  <= p2_idx_r;
      end
    end
  end

  assign out_data = out_r;

endmodule

// File: sv/color_palette_nearest_match.sv
// Palette of 256 packed 24-bit colors with a nearest-color search. Each input word carries
// one operation and yields exactly one result word. Set, get, reset entry, load default and
// the unused codes go from the execute state to the done state; reset all copies the 16 base
// entries from the default store one per cycle over the single palette write port; nearest
// match reads one palette entry per cycle through the single read port and runs two
// pipeline stages behind it. One word is worked on at a time, and a new word is taken while
// the previous result still waits at the output register.
module color_palette_nearest_match
  import cpnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  cpnm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cpnm_out_t out_data
);

  cpnm_cmd_t    cmd;
  cpnm_status_t status;

  cpnm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cpnm_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_data    (out_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
